/* sv/pqad_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqad_pkg
// Shared types and constants of the product-quantization distance scan:
// item kinds, field widths and the distance table write bundle.
// ----------------------------------------------------------------------------
package pqad_pkg;

   // Item kinds on the request channel.
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CODE  = 2'd2;

   // Field and datapath widths.
   localparam int VAL_W  = 16;
   localparam int DIFF_W = VAL_W + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int TBL_W  = 36;
   localparam int DIST_W = 40;
   localparam int IDX_W  = 32;

   // Write side of the distance table.
   typedef struct packed {
      logic             en;
      logic [TBL_W-1:0] data;
   } tbl_wr_type;

   // Index width of a store with n entries, at least one bit.
   function automatic int idx_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

/* sv/pq_asymmetric_distance_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pq_asymmetric_distance_scan
// Product-quantization distance engine: codebook, query table and code scan.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_ready. A codebook element (kind 0) is
//   written into the codebook memory. A query element (kind 1) walks every
//   centroid of its subspace through the codebook and the distance table
//   memories, one table write per centroid through a three-stage
//   read/square/write pipeline; req_ready stays low from the query transfer
//   until the last write. Code bytes (kind 2) stream at one per cycle while
//   req_ready is high, one per subspace in order; each reads one table entry.
//   A result transfer on rsp_valid/rsp_ready follows the last code byte of
//   a vector: the byte and its table read are registered, then summed into
//   the result register, which raises rsp_valid.
//   The result register lets the next vector's bytes flow in while a result
//   waits; if a vector completes while the previous result is still held,
//   req_ready drops until the receiver takes it.
//   Reset clears the code position, the running sum and the vector counter.
//   The memories are not cleared; run a full query over the codebook
//   before scanning codes.
// ----------------------------------------------------------------------------
module pq_asymmetric_distance_scan #(
   parameter int SUBSPACES = 8,
   parameter int CENTROIDS = 256,
   parameter int SUBDIM    = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pqad_pkg::KIND_W-1:0]         req_kind,
   input  logic [3:0]                          req_subspace,
   input  logic [7:0]                          req_centroid,
   input  logic [3:0]                          req_component,
   input  logic signed [pqad_pkg::VAL_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pqad_pkg::DIST_W-1:0]         rsp_distance,
   output logic [pqad_pkg::IDX_W-1:0]          rsp_vector_index
);

   localparam int SUB_W    = pqad_pkg::idx_width(SUBSPACES);
   localparam int CEN_W    = pqad_pkg::idx_width(CENTROIDS);
   localparam int DIM_W    = pqad_pkg::idx_width(SUBDIM);
   localparam int CB_AW    = pqad_pkg::idx_width(SUBSPACES * CENTROIDS * SUBDIM);
   localparam int TB_DEPTH = SUBSPACES * CENTROIDS;
   localparam int TB_AW    = pqad_pkg::idx_width(TB_DEPTH);

   logic                        accept;
   logic                        sub_ok;
   logic                        cen_ok;
   logic                        comp_ok;
   logic                        load_en;
   logic                        q_start;
   logic                        code_en;
   logic                        q_busy;
   logic                        acc_stall;
   logic [SUB_W-1:0]            code_pos;
   logic [CEN_W-1:0]            cen_idx;
   logic [TB_AW-1:0]            code_addr;
   logic                        q_rd_en;
   logic [TB_AW-1:0]            q_rd_addr;
   logic                        tb_rd_en;
   logic [TB_AW-1:0]            tb_rd_addr;
   logic [pqad_pkg::TBL_W-1:0]  tb_rd_data;
   pqad_pkg::tbl_wr_type        tb_wr;
   logic [TB_AW-1:0]            tb_wr_addr;

   // Request transfer and decode; out-of-range elements are taken and dropped.
   assign req_ready = ~q_busy & ~acc_stall;
   assign accept    = req_valid & req_ready;
   assign sub_ok    = int'(req_subspace) < SUBSPACES;
   assign cen_ok    = int'(req_centroid) < CENTROIDS;
   assign comp_ok   = int'(req_component) < SUBDIM;
   assign load_en   = accept & (req_kind == pqad_pkg::KIND_LOAD) & sub_ok & cen_ok & comp_ok;
   assign q_start   = accept & (req_kind == pqad_pkg::KIND_QUERY) & sub_ok & comp_ok;
   assign code_en   = accept & (req_kind == pqad_pkg::KIND_CODE);
   assign cen_idx   = req_centroid[CEN_W-1:0];

   // Table address of a code byte; an out-of-range byte reads entry zero.
   always_comb begin
      int ca;
      ca        = int'(code_pos) * CENTROIDS + int'(cen_idx);
      code_addr = cen_ok ? TB_AW'(ca) : '0;
   end

   // The walk and the code scan never read the table in the same cycle.
   assign tb_rd_en   = q_rd_en | code_en;
   assign tb_rd_addr = q_rd_en ? q_rd_addr : code_addr;

   pqad_query_unit #(
      .SUBSPACES (SUBSPACES),
      .CENTROIDS (CENTROIDS),
      .SUBDIM    (SUBDIM),
      .SUB_W     (SUB_W),
      .CEN_W     (CEN_W),
      .DIM_W     (DIM_W),
      .CB_AW     (CB_AW),
      .TB_AW     (TB_AW)
   ) u_query (
      .clock      (clock),
      .reset      (reset),
      .load_en    (load_en),
      .load_sub   (req_subspace[SUB_W-1:0]),
      .load_cen   (cen_idx),
      .load_comp  (req_component[DIM_W-1:0]),
      .load_value (req_value),
      .start      (q_start),
      .q_sub      (req_subspace[SUB_W-1:0]),
      .q_comp     (req_component[DIM_W-1:0]),
      .q_value    (req_value),
      .busy       (q_busy),
      .tb_rd_en   (q_rd_en),
      .tb_rd_addr (q_rd_addr),
      .tb_rd_data (tb_rd_data),
      .tb_wr      (tb_wr),
      .tb_wr_addr (tb_wr_addr)
   );

   pqad_dist_table #(
      .DEPTH (TB_DEPTH),
      .AW    (TB_AW)
   ) u_table (
      .clock   (clock),
      .rd_en   (tb_rd_en),
      .rd_addr (tb_rd_addr),
      .rd_data (tb_rd_data),
      .wr      (tb_wr),
      .wr_addr (tb_wr_addr)
   );

   pqad_code_accum #(
      .SUBSPACES (SUBSPACES),
      .SUB_W     (SUB_W)
   ) u_accum (
      .clock            (clock),
      .reset            (reset),
      .code_en          (code_en),
      .code_hit         (cen_ok),
      .pos              (code_pos),
      .table_data       (tb_rd_data),
      .stall            (acc_stall),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_distance     (rsp_distance),
      .rsp_vector_index (rsp_vector_index)
   );

endmodule

/* sv/pqad_dist_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqad_dist_table
// Squared-distance table: one write port and one registered read port.
// ----------------------------------------------------------------------------
module pqad_dist_table #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [pqad_pkg::TBL_W-1:0]    rd_data,
   input  pqad_pkg::tbl_wr_type          wr,
   input  logic [AW-1:0]                 wr_addr
);

   logic [pqad_pkg::TBL_W-1:0] mem [DEPTH];
   logic [pqad_pkg::TBL_W-1:0] rd_data_ff;

   // The read register holds its value while no read is issued.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pqad_query_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqad_query_unit
// Codebook store and the query walk. A query element sweeps all centroids
// of its subspace: read codeword component, square the difference, then
// overwrite or accumulate the table entry of that centroid.
// ----------------------------------------------------------------------------
module pqad_query_unit #(
   parameter int SUBSPACES = 8,
   parameter int CENTROIDS = 256,
   parameter int SUBDIM    = 4,
   parameter int SUB_W     = 3,
   parameter int CEN_W     = 8,
   parameter int DIM_W     = 2,
   parameter int CB_AW     = 13,
   parameter int TB_AW     = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   // Codebook element load.
   input  logic                              load_en,
   input  logic [SUB_W-1:0]                  load_sub,
   input  logic [CEN_W-1:0]                  load_cen,
   input  logic [DIM_W-1:0]                  load_comp,
   input  logic signed [pqad_pkg::VAL_W-1:0] load_value,
   // Query element start.
   input  logic                              start,
   input  logic [SUB_W-1:0]                  q_sub,
   input  logic [DIM_W-1:0]                  q_comp,
   input  logic signed [pqad_pkg::VAL_W-1:0] q_value,
   output logic                              busy,
   // Distance table access.
   output logic                              tb_rd_en,
   output logic [TB_AW-1:0]                  tb_rd_addr,
   input  logic [pqad_pkg::TBL_W-1:0]        tb_rd_data,
   output pqad_pkg::tbl_wr_type              tb_wr,
   output logic [TB_AW-1:0]                  tb_wr_addr
);

   localparam int CB_DEPTH = SUBSPACES * CENTROIDS * SUBDIM;

   logic signed [pqad_pkg::VAL_W-1:0] cb_mem [CB_DEPTH];
   logic signed [pqad_pkg::VAL_W-1:0] cb_rd_ff;

   // Walk state.
   logic                               run_ff;
   logic [CEN_W-1:0]                   k_ff;
   logic [SUB_W-1:0]                   m_ff;
   logic [DIM_W-1:0]                   d_ff;
   logic signed [pqad_pkg::VAL_W-1:0]  q_ff;
   logic                               first_ff;

   // Square and write-back stages.
   logic                               s1_valid_ff;
   logic [CEN_W-1:0]                   s1_k_ff;
   logic                               s2_valid_ff;
   logic [CEN_W-1:0]                   s2_k_ff;
   logic [pqad_pkg::SQ_W-1:0]          s2_sq_ff;
   logic [pqad_pkg::TBL_W-1:0]         s2_tbl_ff;

   logic [CB_AW-1:0]                   cb_wr_addr;
   logic [CB_AW-1:0]                   cb_rd_addr;
   logic signed [pqad_pkg::DIFF_W-1:0] diff;
   logic signed [pqad_pkg::SQ_W-1:0]   prod;
   logic [pqad_pkg::TBL_W-1:0]         sq_ext;

   // Address arithmetic with constant multipliers.
   always_comb begin
      int wa;
      int ra;
      int ta;
      int tw;
      wa = (int'(load_sub) * CENTROIDS + int'(load_cen)) * SUBDIM + int'(load_comp);
      ra = (int'(m_ff) * CENTROIDS + int'(k_ff)) * SUBDIM + int'(d_ff);
      ta = int'(m_ff) * CENTROIDS + int'(k_ff);
      tw = int'(m_ff) * CENTROIDS + int'(s2_k_ff);
      cb_wr_addr = CB_AW'(wa);
      cb_rd_addr = CB_AW'(ra);
      tb_rd_addr = TB_AW'(ta);
      tb_wr_addr = TB_AW'(tw);
   end

   // Codebook memory: loads write, the walk reads.
   always_ff @(posedge clock) begin
      if (load_en) begin
         cb_mem[cb_wr_addr] <= load_value;
      end
      if (run_ff) begin
         cb_rd_ff <= cb_mem[cb_rd_addr];
      end
   end

   // Walk control.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         k_ff        <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (start) begin
            run_ff <= 1'b1;
            k_ff   <= '0;
         end else if (run_ff) begin
            k_ff <= k_ff + CEN_W'(1);
            if (k_ff == CEN_W'(CENTROIDS - 1)) begin
               run_ff <= 1'b0;
            end
         end
         s1_valid_ff <= run_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Query operands, held for the whole walk.
   always_ff @(posedge clock) begin
      if (start) begin
         m_ff     <= q_sub;
         d_ff     <= q_comp;
         q_ff     <= q_value;
         first_ff <= (q_comp == '0);
      end
   end

   // Difference and square of the codeword component read last cycle.
   assign diff = pqad_pkg::DIFF_W'(q_ff) - pqad_pkg::DIFF_W'(cb_rd_ff);
   assign prod = diff * diff;

   always_ff @(posedge clock) begin
      s1_k_ff   <= k_ff;
      s2_k_ff   <= s1_k_ff;
      s2_sq_ff  <= prod[pqad_pkg::SQ_W-1:0];
      s2_tbl_ff <= tb_rd_data;
   end

   // Component zero overwrites the entry; later components add modulo 2^36.
   assign sq_ext        = {{(pqad_pkg::TBL_W - pqad_pkg::SQ_W){1'b0}}, s2_sq_ff};
   assign tb_wr.en      = s2_valid_ff;
   assign tb_wr.data    = first_ff ? sq_ext : (s2_tbl_ff + sq_ext);
   assign tb_rd_en      = run_ff;
   assign busy          = run_ff | s1_valid_ff | s2_valid_ff;

   // A new query or a codebook load never lands in a walk in progress.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy)
      else $error("query started while a walk is in progress");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      load_en |-> !busy)
      else $error("codebook written during a query walk");

   // The walk stops after the last centroid.
   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      (run_ff && !start && k_ff == CEN_W'(CENTROIDS - 1)) |=> !run_ff)
      else $error("query walk ran past the last centroid");

   // Back-to-back stages carry consecutive centroids.
   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff) |-> (s1_k_ff == s2_k_ff + CEN_W'(1)))
      else $error("square pipeline out of centroid order");

endmodule

/* sv/pqad_code_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqad_code_accum
// Code byte accumulator: tracks the subspace position, sums table entries
// for one database vector and holds the finished result for transfer.
// ----------------------------------------------------------------------------
module pqad_code_accum #(
   parameter int SUBSPACES = 8,
   parameter int SUB_W     = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              code_en,
   input  logic                              code_hit,
   output logic [SUB_W-1:0]                  pos,
   input  logic [pqad_pkg::TBL_W-1:0]        table_data,
   output logic                              stall,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pqad_pkg::DIST_W-1:0]       rsp_distance,
   output logic [pqad_pkg::IDX_W-1:0]        rsp_vector_index
);

   logic                         pos_last;
   logic [SUB_W-1:0]             pos_ff;
   logic                         c_valid_ff;
   logic                         c_last_ff;
   logic                         c_hit_ff;
   logic [pqad_pkg::DIST_W-1:0]  partial_ff;
   logic [pqad_pkg::IDX_W-1:0]   count_ff;
   logic                         rsp_valid_ff;
   logic [pqad_pkg::DIST_W-1:0]  rsp_distance_ff;
   logic [pqad_pkg::IDX_W-1:0]   rsp_index_ff;
   logic                         fire;
   logic [pqad_pkg::DIST_W-1:0]  addend;
   logic [pqad_pkg::DIST_W-1:0]  sum;

   assign pos_last = (pos_ff == SUB_W'(SUBSPACES - 1));

   // A finished vector waits while the result register is still occupied.
   assign stall  = c_valid_ff & c_last_ff & rsp_valid_ff & ~rsp_ready;
   assign fire   = c_valid_ff & ~stall;
   assign addend = c_hit_ff ?
                   {{(pqad_pkg::DIST_W - pqad_pkg::TBL_W){1'b0}}, table_data} : '0;
   assign sum    = partial_ff + addend;

   // Position, accumulation and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         c_valid_ff   <= 1'b0;
         partial_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (code_en) begin
            pos_ff     <= pos_last ? '0 : pos_ff + SUB_W'(1);
            c_valid_ff <= 1'b1;
         end else if (fire) begin
            c_valid_ff <= 1'b0;
         end
         if (fire) begin
            if (c_last_ff) begin
               partial_ff <= '0;
               count_ff   <= count_ff + pqad_pkg::IDX_W'(1);
            end else begin
               partial_ff <= sum;
            end
         end
         if (fire && c_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item payload and result payload.
   always_ff @(posedge clock) begin
      if (code_en) begin
         c_last_ff <= pos_last;
         c_hit_ff  <= code_hit;
      end
      if (fire && c_last_ff) begin
         rsp_distance_ff <= sum;
         rsp_index_ff    <= count_ff;
      end
   end

   assign pos              = pos_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_distance     = rsp_distance_ff;
   assign rsp_vector_index = rsp_index_ff;

   // No code byte is taken while a finished vector is held back.
   a_no_take_in_stall: assert property (@(posedge clock) disable iff (reset)
      code_en |-> !stall)
      else $error("code byte taken while the accumulator is stalled");

   // A pending last byte has already wrapped the position.
   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && c_last_ff) |-> (pos_ff == '0))
      else $error("position did not wrap after the last subspace");

   // A new result appears only from a completed vector.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(c_valid_ff && c_last_ff))
      else $error("result raised without a completed vector");

endmodule

/* verif/pqad_scan_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqad_scan_checker
// Passive checker for the product-quantization distance scan. It mirrors the
// codebook and the distance table, predicts the distance and the vector
// index of every completed code vector, and compares each result transfer
// with the oldest prediction.
// ----------------------------------------------------------------------------
module pqad_scan_checker #(
   parameter int SUBSPACES = 8,
   parameter int CENTROIDS = 256,
   parameter int SUBDIM    = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [pqad_pkg::KIND_W-1:0]         req_kind,
   input  logic [3:0]                          req_subspace,
   input  logic [7:0]                          req_centroid,
   input  logic [3:0]                          req_component,
   input  logic signed [pqad_pkg::VAL_W-1:0]   req_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [pqad_pkg::DIST_W-1:0]         rsp_distance,
   input  logic [pqad_pkg::IDX_W-1:0]          rsp_vector_index,
   output int                                  mismatch_count,
   output int                                  outstanding
);

   typedef struct packed {
      logic [pqad_pkg::DIST_W-1:0] distance;
      logic [pqad_pkg::IDX_W-1:0]  vector_index;
   } scan_result_type;

   // Mirrors of the two memories and the scan registers.
   logic signed [pqad_pkg::VAL_W-1:0] codebook_mirror [SUBSPACES*CENTROIDS*SUBDIM];
   logic [pqad_pkg::TBL_W-1:0]        dist_lut [SUBSPACES*CENTROIDS];
   int unsigned                       scan_pos;
   logic [pqad_pkg::DIST_W-1:0]       running_sum;
   logic [pqad_pkg::IDX_W-1:0]        vectors_seen;

   scan_result_type expected_results [$];
   scan_result_type oldest;
   int              errors = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      errors++;
   endtask

   // A codebook element lands only when all three indexes are in range.
   task automatic store_codeword(input logic [3:0] sub, input logic [7:0] cen,
                                 input logic [3:0] comp,
                                 input logic signed [pqad_pkg::VAL_W-1:0] val);
      if (sub < SUBSPACES && cen < CENTROIDS && comp < SUBDIM) begin
         codebook_mirror[(sub * CENTROIDS + cen) * SUBDIM + comp] = val;
      end
   endtask

   // A query element squares its difference to every centroid of the
   // subspace; component 0 starts the entry and later ones add modulo 2^36.
   task automatic fold_query(input logic [3:0] sub, input logic [3:0] comp,
                             input logic signed [pqad_pkg::VAL_W-1:0] val);
      longint     qv;
      longint     cv;
      longint     diff;
      logic [63:0] acc;
      if (sub < SUBSPACES && comp < SUBDIM) begin
         qv = val;
         for (int k = 0; k < CENTROIDS; k++) begin
            cv   = codebook_mirror[(sub * CENTROIDS + k) * SUBDIM + comp];
            diff = qv - cv;
            acc  = (comp == 0) ? 64'd0 : 64'(dist_lut[sub * CENTROIDS + k]);
            acc  = acc + 64'(diff * diff);
            dist_lut[sub * CENTROIDS + k] = acc[pqad_pkg::TBL_W-1:0];
         end
      end
   endtask

   // Each code byte adds its table entry; the last subspace closes the vector.
   task automatic scan_code_byte(input logic [7:0] cen);
      scan_result_type done;
      if (cen < CENTROIDS) begin
         running_sum = running_sum +
                       pqad_pkg::DIST_W'(dist_lut[scan_pos * CENTROIDS + cen]);
      end
      if (scan_pos + 1 >= SUBSPACES) begin
         done.distance     = running_sum;
         done.vector_index = vectors_seen;
         expected_results.push_back(done);
         vectors_seen = vectors_seen + 1'b1;
         running_sum  = '0;
         scan_pos     = 0;
      end else begin
         scan_pos = scan_pos + 1;
      end
   endtask

   // Result transfers are checked before the request transfer of the same
   // edge is folded in; a new prediction is always younger than any result.
   always @(posedge clock) begin
      if (reset) begin
         scan_pos     = 0;
         running_sum  = '0;
         vectors_seen = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", 64'(rsp_distance), 64'd0);
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_distance !== oldest.distance) begin
                  report_mismatch($sformatf("distance of vector %0d", oldest.vector_index),
                                  64'(rsp_distance), 64'(oldest.distance));
               end
               if (rsp_vector_index !== oldest.vector_index) begin
                  report_mismatch("vector index", 64'(rsp_vector_index),
                                  64'(oldest.vector_index));
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_kind)
               pqad_pkg::KIND_LOAD: begin
                  store_codeword(req_subspace, req_centroid, req_component, req_value);
               end
               pqad_pkg::KIND_QUERY: begin
                  fold_query(req_subspace, req_component, req_value);
               end
               pqad_pkg::KIND_CODE: begin
                  scan_code_byte(req_centroid);
               end
               default: begin
               end
            endcase
         end
      end
      outstanding    <= expected_results.size();
      mismatch_count <= errors;
   end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the product-quantization distance scan. After a
// full codebook load and a table build, a short directed sequence covers
// field extremes, ignored items, table wrap and queries inside a vector;
// random code vectors, query runs, loads and noise follow, with random
// gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int SUBSPACES     = 8;
   localparam int CENTROIDS     = 256;
   localparam int SUBDIM        = 4;
   localparam int RANDOM_ITEMS  = 400;
   localparam int MIN_RESULTS   = 40;
   localparam int DRAIN_CYCLES  = CENTROIDS + 20;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int OVERFLOW_REPS = 17;
   localparam logic [pqad_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic                               clock;
   logic                               reset         = 1'b1;
   logic                               req_valid     = 1'b0;
   logic                               req_ready;
   logic [pqad_pkg::KIND_W-1:0]        req_kind      = pqad_pkg::KIND_LOAD;
   logic [3:0]                         req_subspace  = '0;
   logic [7:0]                         req_centroid  = '0;
   logic [3:0]                         req_component = '0;
   logic signed [pqad_pkg::VAL_W-1:0]  req_value     = '0;
   logic                               rsp_valid;
   logic                               rsp_ready     = 1'b0;
   logic [pqad_pkg::DIST_W-1:0]        rsp_distance;
   logic [pqad_pkg::IDX_W-1:0]         rsp_vector_index;

   int  mismatch_count;
   int  outstanding;
   int  cycle_count = 0;
   int  live_items  = 0;
   int  code_bytes  = 0;
   bit  calm        = 1'b0;

   pq_asymmetric_distance_scan #(
      .SUBSPACES(SUBSPACES), .CENTROIDS(CENTROIDS), .SUBDIM(SUBDIM)
   ) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_subspace(req_subspace), .req_centroid(req_centroid),
      .req_component(req_component), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_distance(rsp_distance), .rsp_vector_index(rsp_vector_index)
   );

   pqad_scan_checker #(
      .SUBSPACES(SUBSPACES), .CENTROIDS(CENTROIDS), .SUBDIM(SUBDIM)
   ) scan_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_subspace(req_subspace), .req_centroid(req_centroid),
      .req_component(req_component), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_distance(rsp_distance), .rsp_vector_index(rsp_vector_index),
      .mismatch_count(mismatch_count), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the handshakes hang.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long; none while calm.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Component values: mostly uniform, sometimes a corner value.
   function automatic logic [pqad_pkg::VAL_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return pqad_pkg::VAL_W'($urandom);
      endcase
   endfunction

   // One request transfer, started at a falling edge, after an optional gap.
   task automatic send_item(input logic [pqad_pkg::KIND_W-1:0] kind, input logic [3:0] sub,
                            input logic [7:0] cen, input logic [3:0] comp,
                            input logic [pqad_pkg::VAL_W-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_subspace  <= sub;
      req_centroid  <= cen;
      req_component <= comp;
      req_value     <= val;
      do @(posedge clock); while (!req_ready);
      if (kind == pqad_pkg::KIND_CODE) begin
         code_bytes++;
         live_items++;
      end else if ((kind == pqad_pkg::KIND_LOAD || kind == pqad_pkg::KIND_QUERY)
                   && sub < SUBSPACES && comp < SUBDIM && cen < CENTROIDS) begin
         live_items++;
      end
      @(negedge clock);
   endtask

   // Receiver: ready runs of random length broken by random stalls.
   initial begin
      int g;
      @(negedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         g = pick_gap();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
      end
   end

   initial begin
      int                          pick;
      int                          n;
      logic [3:0]                  sub;
      logic [pqad_pkg::VAL_W-1:0]  val;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Fill the whole codebook. Entry (0, 0, 1) is pinned to the most
      // negative value so that repeated queries can wrap its table entry.
      for (int m = 0; m < SUBSPACES; m++) begin
         for (int k = 0; k < CENTROIDS; k++) begin
            for (int d = 0; d < SUBDIM; d++) begin
               val = (m == 0 && k == 0 && d == 1) ? 16'h8000 : pick_value();
               send_item(pqad_pkg::KIND_LOAD, 4'(m), 8'(k), 4'(d), val);
            end
         end
      end

      // Build every table entry, in component order. Subspace 0 component 1
      // is repeated at the far corner until entry 0 wraps past 2^36.
      for (int m = 0; m < SUBSPACES; m++) begin
         for (int d = 0; d < SUBDIM; d++) begin
            if (m == 0 && d == 1) begin
               repeat (OVERFLOW_REPS) begin
                  send_item(pqad_pkg::KIND_QUERY, 4'(m), 8'hFF, 4'(d), 16'h7FFF);
               end
            end else begin
               send_item(pqad_pkg::KIND_QUERY, 4'(m), 8'($urandom), 4'(d), pick_value());
            end
         end
      end

      // Directed: a vector that reads the wrapped entry, junk in the unused
      // fields, and code bytes at both ends of the range.
      for (int p = 0; p < SUBSPACES; p++) begin
         send_item(pqad_pkg::KIND_CODE, 4'hF, (p == 0 || p[0]) ? 8'h00 : 8'hFF, 4'hF,
                   16'hFFFF);
      end

      // Directed: field extremes on the codebook, then the ignored items.
      send_item(pqad_pkg::KIND_LOAD, 4'(SUBSPACES - 1), 8'(CENTROIDS - 1), 4'(SUBDIM - 1),
                16'h7FFF);
      send_item(pqad_pkg::KIND_LOAD, 4'd0, 8'(CENTROIDS - 1), 4'd0, 16'h8000);
      send_item(KIND_UNUSED, 4'hF, 8'hFF, 4'hF, 16'hFFFF);
      send_item(pqad_pkg::KIND_LOAD, 4'hF, 8'h00, 4'd0, 16'h1234);
      send_item(pqad_pkg::KIND_LOAD, 4'd0, 8'h00, 4'(SUBDIM), 16'h7FFF);
      send_item(pqad_pkg::KIND_QUERY, 4'(SUBSPACES), 8'h00, 4'd0, 16'h4321);
      send_item(pqad_pkg::KIND_QUERY, 4'd0, 8'h00, 4'hF, 16'h8000);
      send_item(pqad_pkg::KIND_QUERY, 4'(SUBSPACES - 1), 8'h00, 4'd0, 16'h8000);

      // Directed: a query lands in the middle of a vector.
      for (int p = 0; p < SUBSPACES; p++) begin
         if (p == 3) send_item(pqad_pkg::KIND_QUERY, 4'd5, 8'h00, 4'd1, 16'h7FFF);
         send_item(pqad_pkg::KIND_CODE, 4'h0, 8'hFF, 4'h0, 16'h0000);
      end

      // Random part: mostly whole code vectors, with query runs, loads and
      // some noise in between.
      live_items = 0;
      code_bytes = 0;
      while (live_items < RANDOM_ITEMS || code_bytes / SUBSPACES < MIN_RESULTS) begin
         if ($urandom_range(0, 99) < 3) calm = !calm;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            for (int p = 0; p < SUBSPACES; p++) begin
               if ($urandom_range(0, 99) < 4) begin
                  send_item(pqad_pkg::KIND_QUERY, 4'($urandom_range(0, SUBSPACES - 1)),
                            8'($urandom), 4'($urandom_range(0, SUBDIM - 1)), pick_value());
               end
               send_item(pqad_pkg::KIND_CODE, 4'($urandom), 8'($urandom), 4'($urandom),
                         16'($urandom));
            end
         end else if (pick < 70) begin
            sub = 4'($urandom_range(0, SUBSPACES - 1));
            n   = $urandom_range(1, SUBDIM);
            for (int d = 0; d < n; d++) begin
               send_item(pqad_pkg::KIND_QUERY, sub, 8'($urandom), 4'(d), pick_value());
            end
         end else if (pick < 75) begin
            // Accumulate onto an entry, or restart it when the component is zero.
            send_item(pqad_pkg::KIND_QUERY, 4'($urandom_range(0, SUBSPACES - 1)),
                      8'($urandom), 4'($urandom_range(0, SUBDIM - 1)), pick_value());
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 8)) begin
               send_item(pqad_pkg::KIND_LOAD, 4'($urandom_range(0, SUBSPACES - 1)),
                         8'($urandom_range(0, CENTROIDS - 1)),
                         4'($urandom_range(0, SUBDIM - 1)), pick_value());
            end
         end else begin
            case ($urandom_range(0, 4))
               0: send_item(KIND_UNUSED, 4'($urandom), 8'($urandom), 4'($urandom),
                            16'($urandom));
               1: send_item(pqad_pkg::KIND_LOAD, 4'($urandom_range(SUBSPACES, 15)),
                            8'($urandom), 4'($urandom), 16'($urandom));
               2: send_item(pqad_pkg::KIND_LOAD, 4'($urandom), 8'($urandom),
                            4'($urandom_range(SUBDIM, 15)), 16'($urandom));
               3: send_item(pqad_pkg::KIND_QUERY, 4'($urandom_range(SUBSPACES, 15)),
                            8'($urandom), 4'($urandom), 16'($urandom));
               default: send_item(pqad_pkg::KIND_QUERY, 4'($urandom), 8'($urandom),
                                  4'($urandom_range(SUBDIM, 15)), 16'($urandom));
            endcase
         end
      end
      req_valid <= 1'b0;

      // Let every predicted result arrive, then watch for strays.
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
